// File: rtl/lcdser_pkg.sv
// Shared types and constants for the RGB565 LCD byte stream serializer.
// Holds the payload structs, the queue entry, the configuration write bundle
// and the controller command codes. Depends on nothing.
package lcdser_pkg;

    // Default window limits and queue depth.
    localparam int MAX_COLUMNS_DEF = 240;
    localparam int MAX_ROWS_DEF    = 320;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Configuration register sizes and reset values.
    localparam int WIDTH_W     = 8;
    localparam int HEIGHT_W    = 9;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 2;
    localparam int COUNT_W     = 17;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 8'd240;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 9'd320;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // Controller command codes of the window header.
    localparam logic [7:0] CMD_COLUMN_SET = 8'h2A;
    localparam logic [7:0] CMD_ROW_SET    = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE  = 8'h2C;
    localparam logic [7:0] BYTE_ZERO      = 8'h00;

    // One input pixel.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // One byte of the output stream.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       run_last;
        logic       frame_done;
    } lcd_byte_t;

    // Classified pixel waiting for the byte sequencer.
    typedef struct packed {
        logic [15:0]         color;
        logic                header;
        logic                done;
        logic [WIDTH_W-1:0]  col_end;
        logic [HEIGHT_W-1:0] row_end;
    } queue_entry_t;

    // One configuration write.
    typedef struct packed {
        logic                   we;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  wdata;
    } cfg_write_t;

endpackage

// File: rtl/lcd_frame_rgb565_serializer_unit.sv
// An accepted pixel passes a queue slot, the sequencer entry register and the registered
// output stage. A frame's first pixel also sends the window header; the byte sequencer
// emits one byte per cycle unless m_ready stalls; the two-entry queue lets input continue.
// Reset: synchronous, active low; width 240, height 320, pixel count zero, queue empty.
// Top level: instantiates front end, queue and byte sequencer. Depends on lcdser_pkg.
module lcd_frame_rgb565_serializer_unit #(
    parameter int MAX_COLUMNS = lcdser_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = lcdser_pkg::MAX_ROWS_DEF,
    parameter int QUEUE_DEPTH = lcdser_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [lcdser_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lcdser_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  lcdser_pkg::pixel_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output lcdser_pkg::lcd_byte_t               m_data
);

    lcdser_pkg::cfg_write_t   cfg;
    logic                     push_valid;
    logic                     push_ready;
    lcdser_pkg::queue_entry_t push_data;
    logic                     pop_valid;
    logic                     pop_ready;
    lcdser_pkg::queue_entry_t pop_data;

    // Bundle the configuration write.
    always_comb begin
        cfg.we    = cfg_we;
        cfg.index = cfg_index;
        cfg.wdata = cfg_wdata;
    end

    lcdser_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    lcdser_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    lcdser_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: rtl/lcdser_front.sv
// Front end of the serializer: configuration registers, pixel counter and
// RGB565 packing. Pushes one classified entry per pixel into the queue.
// Depends on lcdser_pkg.
module lcdser_front #(
    parameter int MAX_COLUMNS = lcdser_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = lcdser_pkg::MAX_ROWS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  lcdser_pkg::cfg_write_t    cfg,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  lcdser_pkg::pixel_t        s_data,
    output logic                      push_valid,
    input  logic                      push_ready,
    output lcdser_pkg::queue_entry_t  push_data
);

    logic [lcdser_pkg::WIDTH_W-1:0]  frame_width_reg, frame_width_next;
    logic [lcdser_pkg::HEIGHT_W-1:0] frame_height_reg, frame_height_next;
    logic [lcdser_pkg::COUNT_W-1:0]  pixel_count_reg, pixel_count_next;

    logic [lcdser_pkg::WIDTH_W-1:0]  width_used;
    logic [lcdser_pkg::HEIGHT_W-1:0] height_used;
    logic [lcdser_pkg::COUNT_W-1:0]  frame_total;
    logic [lcdser_pkg::COUNT_W-1:0]  count_inc;
    logic                            frame_end;
    logic                            accept;

    // Window sizes: zero counts as one, and each is capped at its limit.
    always_comb begin
        width_used = frame_width_reg;
        if (width_used == '0) begin
            width_used = lcdser_pkg::WIDTH_W'(1);
        end
        if (32'(width_used) > MAX_COLUMNS) begin
            width_used = lcdser_pkg::WIDTH_W'(MAX_COLUMNS);
        end
        height_used = frame_height_reg;
        if (height_used == '0) begin
            height_used = lcdser_pkg::HEIGHT_W'(1);
        end
        if (32'(height_used) > MAX_ROWS) begin
            height_used = lcdser_pkg::HEIGHT_W'(MAX_ROWS);
        end
    end

    assign frame_total = lcdser_pkg::COUNT_W'(width_used) * lcdser_pkg::COUNT_W'(height_used);
    assign count_inc   = pixel_count_reg + lcdser_pkg::COUNT_W'(1);
    assign frame_end   = (count_inc >= frame_total);

    assign s_ready    = push_ready;
    assign accept     = s_valid && push_ready;
    assign push_valid = s_valid;

    // Classified entry for the sequencer.
    always_comb begin
        push_data.color   = {s_data.red[7:3], s_data.green[7:2], s_data.blue[7:3]};
        push_data.header  = (pixel_count_reg == '0);
        push_data.done    = frame_end;
        push_data.col_end = width_used - lcdser_pkg::WIDTH_W'(1);
        push_data.row_end = height_used - lcdser_pkg::HEIGHT_W'(1);
    end

    // Next values of the configuration registers and the pixel counter.
    always_comb begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        pixel_count_next  = pixel_count_reg;
        if (cfg.we) begin
            case (cfg.index)
                lcdser_pkg::REG_FRAME_WIDTH: begin
                    frame_width_next = cfg.wdata[lcdser_pkg::WIDTH_W-1:0];
                end
                lcdser_pkg::REG_FRAME_HEIGHT: begin
                    frame_height_next = cfg.wdata[lcdser_pkg::HEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
        if (accept) begin
            pixel_count_next = frame_end ? '0 : count_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= lcdser_pkg::WIDTH_RESET;
            frame_height_reg <= lcdser_pkg::HEIGHT_RESET;
            pixel_count_reg  <= '0;
        end else begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            pixel_count_reg  <= pixel_count_next;
        end
    end

endmodule

// File: rtl/lcdser_queue.sv
// Small queue of classified pixels between the front end and the sequencer.
// Register-based storage with read and write pointers and a fill count.
// Depends on lcdser_pkg.
module lcdser_queue #(
    parameter int DEPTH = lcdser_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push_valid,
    output logic                      push_ready,
    input  lcdser_pkg::queue_entry_t  push_data,
    output logic                      pop_valid,
    input  logic                      pop_ready,
    output lcdser_pkg::queue_entry_t  pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lcdser_pkg::queue_entry_t slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (fill_reg != CNT_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer wrap and fill count.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   fill_next = fill_reg + CNT_W'(1);
            2'b01:   fill_next = fill_reg - CNT_W'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/lcdser_back.sv
// Byte sequencer of the serializer: walks the window header of a frame's first pixel and
// the two color bytes of each queued pixel into a registered output stage.
// Depends on lcdser_pkg.
module lcdser_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      pop_valid,
    output logic                      pop_ready,
    input  lcdser_pkg::queue_entry_t  pop_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output lcdser_pkg::lcd_byte_t     m_data
);

    typedef enum logic [3:0] {
        STEP_COL_CMD   = 4'd0,
        STEP_COL_SH    = 4'd1,
        STEP_COL_SL    = 4'd2,
        STEP_COL_EH    = 4'd3,
        STEP_COL_EL    = 4'd4,
        STEP_ROW_CMD   = 4'd5,
        STEP_ROW_SH    = 4'd6,
        STEP_ROW_SL    = 4'd7,
        STEP_ROW_EH    = 4'd8,
        STEP_ROW_EL    = 4'd9,
        STEP_WRITE_CMD = 4'd10,
        STEP_PIX_HI    = 4'd11,
        STEP_PIX_LO    = 4'd12
    } step_t;

    step_t                    step_reg, step_next;
    logic                     busy_reg, busy_next;
    logic                     m_valid_reg, m_valid_next;
    lcdser_pkg::lcd_byte_t    m_data_reg, m_data_next;
    lcdser_pkg::queue_entry_t entry_reg, entry_next;
    lcdser_pkg::lcd_byte_t    cur_byte;
    logic                     out_free;
    logic                     can_load;

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Byte for the current step.
    always_comb begin
        cur_byte.out_byte   = lcdser_pkg::BYTE_ZERO;
        cur_byte.is_data    = 1'b1;
        cur_byte.run_last   = 1'b0;
        cur_byte.frame_done = 1'b0;
        case (step_reg)
            STEP_COL_CMD: begin
                cur_byte.out_byte = lcdser_pkg::CMD_COLUMN_SET;
                cur_byte.is_data  = 1'b0;
            end
            STEP_COL_SH, STEP_COL_SL, STEP_COL_EH,
            STEP_ROW_SH, STEP_ROW_SL: begin
                cur_byte.out_byte = lcdser_pkg::BYTE_ZERO;
            end
            STEP_COL_EL: begin
                cur_byte.out_byte = entry_reg.col_end;
            end
            STEP_ROW_CMD: begin
                cur_byte.out_byte = lcdser_pkg::CMD_ROW_SET;
                cur_byte.is_data  = 1'b0;
            end
            STEP_ROW_EH: begin
                cur_byte.out_byte = {7'd0, entry_reg.row_end[8]};
            end
            STEP_ROW_EL: begin
                cur_byte.out_byte = entry_reg.row_end[7:0];
            end
            STEP_WRITE_CMD: begin
                cur_byte.out_byte = lcdser_pkg::CMD_MEM_WRITE;
                cur_byte.is_data  = 1'b0;
            end
            STEP_PIX_HI: begin
                cur_byte.out_byte = entry_reg.color[15:8];
            end
            STEP_PIX_LO: begin
                cur_byte.out_byte   = entry_reg.color[7:0];
                cur_byte.run_last   = 1'b1;
                cur_byte.frame_done = entry_reg.done;
            end
            default: begin
            end
        endcase
    end

    // A new entry is taken when idle or while the last byte goes out.
    assign can_load  = !busy_reg || (out_free && (step_reg == STEP_PIX_LO));
    assign pop_ready = can_load;

    always_comb begin
        step_next    = step_reg;
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        entry_next   = entry_reg;
        if (out_free) begin
            m_valid_next = busy_reg;
            if (busy_reg) begin
                m_data_next = cur_byte;
                if (step_reg == STEP_PIX_LO) begin
                    busy_next = 1'b0;
                end else begin
                    step_next = step_t'(step_reg + 4'd1);
                end
            end
        end
        if (can_load && pop_valid) begin
            entry_next = pop_data;
            busy_next  = 1'b1;
            step_next  = pop_data.header ? STEP_COL_CMD : STEP_PIX_HI;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= STEP_COL_CMD;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        entry_reg  <= entry_next;
    end

endmodule
